// ===== hw/rtl/bshr_pkg.sv =====
// Shared types and constants for the button sampler with hold and release reporting.
// No dependencies.
package bshr_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned CFG_W  = 16;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
    localparam logic [CFG_W-1:0] HOLD_TO_RST  = 16'd1000;

    typedef enum logic {
        REG_DEBOUNCE = 1'b0,
        REG_HOLD_TO  = 1'b1
    } t_reg_idx;

    typedef enum logic {
        KIND_HOLD    = 1'b0,
        KIND_RELEASE = 1'b1
    } t_kind;

    typedef struct packed {
        logic              kind;
        logic              pin_level;
        logic [TIME_W-1:0] now_ms;
    } t_item;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] hold_timeout_ms;
    } t_cfg;

endpackage

// ===== hw/rtl/bshr_core.sv =====
// Sampler state and single-pass update for one query beat.
// Depends on bshr_pkg.
module bshr_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_fire,
    input  bshr_pkg::t_item i_item,
    input  bshr_pkg::t_cfg  i_cfg,
    output logic           o_answer
);

    logic                        r_running, n_running;
    logic [bshr_pkg::TIME_W-1:0] r_period_start, n_period_start;
    logic                        r_older, n_older;
    logic                        r_newer, n_newer;
    logic                        r_armed, n_armed;
    logic                        r_hold_evt, n_hold_evt;
    logic                        r_changed, n_changed;
    logic                        r_rel_evt, n_rel_evt;
    logic [bshr_pkg::TIME_W-1:0] r_press_start, n_press_start;

    logic [bshr_pkg::TIME_W-1:0] period_age;
    logic [bshr_pkg::TIME_W-1:0] press_age;
    logic                        period_done;
    logic                        press_long;

    assign period_age  = i_item.now_ms - r_period_start;
    assign press_age   = i_item.now_ms - r_press_start;
    assign period_done = period_age >= {{(bshr_pkg::TIME_W-bshr_pkg::CFG_W){1'b0}},
                                        i_cfg.debounce_ms};
    assign press_long  = press_age >= {{(bshr_pkg::TIME_W-bshr_pkg::CFG_W){1'b0}},
                                       i_cfg.hold_timeout_ms};

    always_comb begin
        n_running      = r_running;
        n_period_start = r_period_start;
        n_older        = r_older;
        n_newer        = r_newer;
        n_armed        = r_armed;
        n_hold_evt     = r_hold_evt;
        n_changed      = r_changed;
        n_rel_evt      = r_rel_evt;
        n_press_start  = r_press_start;
        o_answer       = 1'b0;

        if (!r_running) begin
            n_running      = 1'b1;
            n_period_start = i_item.now_ms;
        end else if (period_done) begin
            n_running = 1'b0;
            n_older   = r_newer;
            n_newer   = !i_item.pin_level;
            if (n_newer != n_older) begin
                if (r_armed) begin
                    n_rel_evt = !n_newer;
                end
                n_armed    = 1'b1;
                n_hold_evt = 1'b0;
                n_changed  = 1'b1;
                if (n_newer) begin
                    n_press_start = i_item.now_ms;
                end
            end else begin
                n_changed = 1'b0;
            end
            // press timer is unchanged whenever both samples are pressed
            if (n_armed && n_newer && n_older && press_long) begin
                n_hold_evt = 1'b1;
            end
        end

        case (bshr_pkg::t_kind'(i_item.kind))
            bshr_pkg::KIND_HOLD: begin
                o_answer = n_hold_evt;
                if (n_hold_evt) begin
                    n_hold_evt = 1'b0;
                    n_armed    = 1'b0;
                end
            end
            bshr_pkg::KIND_RELEASE: begin
                if (n_changed) begin
                    o_answer  = n_rel_evt;
                    n_rel_evt = 1'b0;
                end
            end
            default: begin
                o_answer = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running      <= 1'b0;
            r_period_start <= '0;
            r_older        <= 1'b0;
            r_newer        <= 1'b0;
            r_armed        <= 1'b0;
            r_hold_evt     <= 1'b0;
            r_changed      <= 1'b0;
            r_rel_evt      <= 1'b0;
            r_press_start  <= '0;
        end else if (i_fire) begin
            r_running      <= n_running;
            r_period_start <= n_period_start;
            r_older        <= n_older;
            r_newer        <= n_newer;
            r_armed        <= n_armed;
            r_hold_evt     <= n_hold_evt;
            r_changed      <= n_changed;
            r_rel_evt      <= n_rel_evt;
            r_press_start  <= n_press_start;
        end
    end

endmodule

// ===== hw/rtl/button_sampler_hold_release.sv =====
// Top level: input register, configuration registers, result register.
// Depends on bshr_pkg and bshr_core.
//
//   channel  handshake                 payload
//   query    i_in_valid / o_in_ready   i_kind, i_pin_level, i_now_ms
//   answer   o_out_valid / i_out_ready o_answer
//   config   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One query per cycle unless the answer stalls; answers come from the result register.
// The update is one pass through two 32-bit subtract-compares and flag logic.
// Reset clears all sampler state and loads debounce 50 ms, hold timeout 1000 ms.
// A stalled answer holds; one further query is taken into the input register.
module button_sampler_hold_release (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_kind,
    input  logic        i_pin_level,
    input  logic [31:0] i_now_ms,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_answer,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic            r_in_vld;
    bshr_pkg::t_item r_item;
    logic            r_out_vld;
    logic            r_answer;
    bshr_pkg::t_cfg  r_cfg;
    logic            advance;
    logic            core_answer;

    assign advance     = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !r_in_vld || advance;
    assign o_out_valid = r_out_vld;
    assign o_answer    = r_answer;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.kind      <= i_kind;
            r_item.pin_level <= i_pin_level;
            r_item.now_ms    <= i_now_ms;
        end
        if (advance) begin
            r_answer <= core_answer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms     <= bshr_pkg::DEBOUNCE_RST;
            r_cfg.hold_timeout_ms <= bshr_pkg::HOLD_TO_RST;
        end else if (i_cfg_valid) begin
            case (bshr_pkg::t_reg_idx'(i_cfg_index))
                bshr_pkg::REG_DEBOUNCE: r_cfg.debounce_ms     <= i_cfg_data;
                bshr_pkg::REG_HOLD_TO:  r_cfg.hold_timeout_ms <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    bshr_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_item),
        .i_cfg    (r_cfg),
        .o_answer (core_answer)
    );

endmodule

// ===== bench/button_sampler_hold_release_test.sv =====
// Self-checking bench for button_sampler_hold_release: sampling, hold and release queries.
// Drives queries and register writes, predicts every answer in a scoreboard class and checks it.
// Depends on bshr_pkg and the button_sampler_hold_release RTL.
`timescale 1ns / 100ps

module button_sampler_hold_release_test;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_BEATS = 80;

    class answer_board;
        logic [bshr_pkg::CFG_W-1:0]  debounce;
        logic [bshr_pkg::CFG_W-1:0]  hold_limit;
        bit                          sampling;
        logic [bshr_pkg::TIME_W-1:0] window_start;
        bit                          prev_down;
        bit                          cur_down;
        bit                          armed;
        bit                          hold_flag;
        bit                          level_moved;
        bit                          release_flag;
        logic [bshr_pkg::TIME_W-1:0] down_since;
        bit                          answers_due[$];
        int                          errors;
        int                          queries;
        int                          answers;
        int                          holds_seen;
        int                          releases_seen;

        function new();
            debounce      = bshr_pkg::DEBOUNCE_RST;
            hold_limit    = bshr_pkg::HOLD_TO_RST;
            sampling      = 1'b0;
            window_start  = '0;
            prev_down     = 1'b0;
            cur_down      = 1'b0;
            armed         = 1'b0;
            hold_flag     = 1'b0;
            level_moved   = 1'b0;
            release_flag  = 1'b0;
            down_since    = '0;
            errors        = 0;
            queries       = 0;
            answers       = 0;
            holds_seen    = 0;
            releases_seen = 0;
        endfunction

        function void load_reg(bshr_pkg::t_reg_idx idx, logic [bshr_pkg::CFG_W-1:0] val);
            if (idx == bshr_pkg::REG_DEBOUNCE) begin
                debounce = val;
            end else begin
                hold_limit = val;
            end
        endfunction

        function void note_query(bshr_pkg::t_kind kind, logic pin,
                                 logic [bshr_pkg::TIME_W-1:0] now);
            logic [bshr_pkg::TIME_W-1:0] elapsed;
            bit                          ans;
            ans = 1'b0;
            if (!sampling) begin
                sampling     = 1'b1;
                window_start = now;
            end else begin
                elapsed = now - window_start;
                if (elapsed >= {16'b0, debounce}) begin
                    sampling  = 1'b0;
                    prev_down = cur_down;
                    cur_down  = !pin;
                    if (cur_down != prev_down) begin
                        if (armed) begin
                            release_flag = !cur_down;
                        end
                        armed       = 1'b1;
                        hold_flag   = 1'b0;
                        level_moved = 1'b1;
                        if (cur_down) begin
                            down_since = now;
                        end
                    end else begin
                        level_moved = 1'b0;
                    end
                    elapsed = now - down_since;
                    if (armed && cur_down && prev_down && elapsed >= {16'b0, hold_limit}) begin
                        hold_flag = 1'b1;
                    end
                end
            end
            if (kind == bshr_pkg::KIND_HOLD) begin
                if (hold_flag) begin
                    ans       = 1'b1;
                    armed     = 1'b0;
                    hold_flag = 1'b0;
                    holds_seen++;
                end
            end else if (level_moved) begin
                ans          = release_flag;
                release_flag = 1'b0;
                if (ans) begin
                    releases_seen++;
                end
            end
            answers_due.push_back(ans);
            queries++;
        endfunction

        task report_mismatch(string msg);
            $display("%0d ns: mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_answer(logic got);
            bit want;
            answers++;
            if (answers_due.size() == 0) begin
                report_mismatch("answer beat arrived with no query outstanding");
            end else begin
                want = answers_due.pop_front();
                if (got !== want) begin
                    report_mismatch($sformatf("answer %b, predicted %b (answer beat %0d)",
                                              got, want, answers));
                end
            end
        endtask

        function int pending();
            return answers_due.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_kind;
    logic        i_pin_level;
    logic [31:0] i_now_ms;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_answer;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [15:0] i_cfg_data;

    answer_board board;
    int          cycles = 0;
    int          settings = 0;
    bit          tx_quiet = 1'b0;
    bit          rx_quiet = 1'b0;

    button_sampler_hold_release u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .i_pin_level (i_pin_level),
        .i_now_ms    (i_now_ms),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_answer    (o_answer),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("button_sampler_hold_release_test: done, errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            board.check_answer(o_answer);
        end
    end

    // answer side: stall at random, with quiet stretches
    initial begin
        int stall;
        i_out_ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            if ($urandom_range(0, 15) == 0) begin
                rx_quiet = !rx_quiet;
            end
            stall = rx_quiet ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
        end
    end

    task automatic send_query(input bshr_pkg::t_kind kind, input logic pin,
                              input logic [31:0] now);
        int gap;
        if ($urandom_range(0, 15) == 0) begin
            tx_quiet = !tx_quiet;
        end
        gap = tx_quiet ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_kind      <= kind;
        i_pin_level <= pin;
        i_now_ms    <= now;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        board.note_query(kind, pin, now);
    endtask

    task automatic write_beat(input bshr_pkg::t_reg_idx idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        board.load_reg(idx, val);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [15:0] deb, input logic [15:0] hold);
        bit hold_first;
        hold_first = 1'($urandom_range(0, 1));
        if (hold_first) begin
            write_beat(bshr_pkg::REG_HOLD_TO, hold);
            write_beat(bshr_pkg::REG_DEBOUNCE, deb);
        end else begin
            write_beat(bshr_pkg::REG_DEBOUNCE, deb);
            write_beat(bshr_pkg::REG_HOLD_TO, hold);
        end
        i_cfg_valid <= 1'b0;
        settings++;
    endtask

    // mostly clean press and release runs over advancing time; the rest glitches and jumps
    task automatic run_phase(input logic [15:0] deb, input logic [15:0] hold, input int beats);
        int          max_step;
        int          run;
        bit          held;
        logic        pin;
        logic [31:0] t;
        max_step = deb + (hold >> 3) + 8;
        held     = 1'($urandom_range(0, 1));
        run      = $urandom_range(1, 24);
        if ($urandom_range(0, 3) == 0) begin
            t = 32'hFFFF_FFFF - $urandom_range(0, 4 * max_step);
        end else begin
            t = $urandom;
        end
        for (int n = 0; n < beats; n++) begin
            if ($urandom_range(0, 99) < 12) begin
                pin = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 1) == 1) begin
                    t = $urandom;
                end else begin
                    t = t + $urandom_range(0, max_step);
                end
            end else begin
                if (run == 0) begin
                    held = !held;
                    run  = $urandom_range(1, 24);
                end
                run--;
                pin = !held;
                t   = t + $urandom_range(0, max_step);
            end
            send_query(bshr_pkg::t_kind'($urandom_range(0, 1)), pin, t);
        end
    endtask

    initial begin
        logic [15:0] deb;
        logic [15:0] hold;
        board = new();
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_kind      <= bshr_pkg::KIND_HOLD;
        i_pin_level <= 1'b1;
        i_now_ms    <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= bshr_pkg::REG_DEBOUNCE;
        i_cfg_data  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: press, hold, release, time wrap
        send_query(bshr_pkg::KIND_HOLD,    1'b1, 32'd0);
        send_query(bshr_pkg::KIND_RELEASE, 1'b0, 32'd49);
        send_query(bshr_pkg::KIND_RELEASE, 1'b0, 32'd50);
        send_query(bshr_pkg::KIND_HOLD,    1'b0, 32'd60);
        send_query(bshr_pkg::KIND_HOLD,    1'b0, 32'd1100);
        send_query(bshr_pkg::KIND_HOLD,    1'b1, 32'd1110);
        send_query(bshr_pkg::KIND_RELEASE, 1'b1, 32'd1200);
        send_query(bshr_pkg::KIND_HOLD,    1'b0, 32'd1210);
        send_query(bshr_pkg::KIND_HOLD,    1'b0, 32'd1300);
        send_query(bshr_pkg::KIND_RELEASE, 1'b0, 32'd1310);
        send_query(bshr_pkg::KIND_RELEASE, 1'b1, 32'd1400);
        send_query(bshr_pkg::KIND_RELEASE, 1'b1, 32'd1410);
        send_query(bshr_pkg::KIND_HOLD,    1'b0, 32'hFFFF_FFC0);
        send_query(bshr_pkg::KIND_HOLD,    1'b0, 32'h0000_0010);
        send_query(bshr_pkg::KIND_HOLD,    1'b1, 32'hFFFF_FFFF);
        send_query(bshr_pkg::KIND_RELEASE, 1'b1, 32'h0000_0000);
        send_query(bshr_pkg::KIND_RELEASE, 1'b1, 32'h0000_0031);
        send_query(bshr_pkg::KIND_HOLD,    1'b1, 32'h0000_0040);
        send_query(bshr_pkg::KIND_HOLD,    1'b0, 32'h0000_0040);

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: begin deb = 16'd0;     hold = 16'd0;     end
                1: begin deb = 16'hFFFF;  hold = 16'hFFFF;  end
                2: begin deb = 16'd0;     hold = 16'hFFFF;  end
                3: begin deb = 16'hFFFF;  hold = 16'd0;     end
                4: begin deb = bshr_pkg::DEBOUNCE_RST; hold = bshr_pkg::HOLD_TO_RST; end
                7: begin deb = 16'($urandom); hold = 16'($urandom); end
                default: begin
                    deb  = 16'($urandom_range(1, 40));
                    hold = 16'($urandom_range(1, 400));
                end
            endcase
            wait_idle();
            program_regs(deb, hold);
            run_phase(deb, hold, PHASE_BEATS);
        end
        wait_idle();
        repeat (8) @(posedge i_clk);

        $display("button_sampler_hold_release_test: %0d queries, %0d register settings",
                 board.queries, settings);
        $display("  answers checked %0d, holds %0d, releases %0d, mismatches %0d",
                 board.answers, board.holds_seen, board.releases_seen, board.errors);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("button_sampler_hold_release_test: done, clean");
        end else begin
            $display("button_sampler_hold_release_test: done, errors");
        end
        $finish;
    end

endmodule
